// ===== rtl/core/skt_pkg.sv =====
`default_nettype none

package skt_pkg;

    // Field widths of one command and of one response.
    localparam int unsigned CMD_W = 2;
    localparam int unsigned KEY_W = 31;
    localparam int unsigned AGE_W = 31;
    localparam int unsigned ST_W  = 2;
    localparam int unsigned CNT_W = 7;

    // Command codes.
    localparam logic [CMD_W-1:0] OP_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [CMD_W-1:0] OP_UPDATE = 2'd2;
    localparam logic [CMD_W-1:0] OP_DELETE = 2'd3;

    // Response status codes.
    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [ST_W-1:0] ST_PRESENT   = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic            load;      // capture the incoming command
        logic            rd;        // read the table at the pointer
        logic            rd_dn;     // read below the pointer and count down
        logic            scan;      // compare returned entries
        logic            del_init;  // pointer to the entry after the hit
        logic            wr_dn;     // move returned entry one place down
        logic            ins_init;  // pointer to the record count
        logic            wr_up;     // move returned entry one place up
        logic            put;       // write the new record at its place
        logic            dec_cnt;   // one record fewer
        logic            set_code;  // latch the response status
        logic [ST_W-1:0] code;
        logic            finish;    // load the response register
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [CMD_W-1:0] op;
        logic             hit;
        logic             nhit;
        logic             full;
        logic             ptr_end;
        logic             ins_end;
        logic             rvld;
        logic             out_free;
    } t_ctl_sts;

endpackage

`default_nettype wire

// ===== rtl/core/skt_if.sv =====
`default_nettype none

interface skt_in_if;
    logic                            valid;
    logic                            ready;
    logic [skt_pkg::CMD_W-1:0]       command;
    logic [skt_pkg::KEY_W-1:0]       key;
    logic [skt_pkg::KEY_W-1:0]       new_key;
    logic [skt_pkg::AGE_W-1:0]       age;

    modport source (output valid, output command, output key, output new_key,
                    output age, input ready);
    modport sink   (input valid, input command, input key, input new_key,
                    input age, output ready);
endinterface

interface skt_out_if;
    logic                            valid;
    logic                            ready;
    logic [skt_pkg::ST_W-1:0]        status;
    logic [skt_pkg::AGE_W-1:0]       found_age;
    logic [skt_pkg::CNT_W-1:0]       entry_count;

    modport source (output valid, output status, output found_age,
                    output entry_count, input ready);
    modport sink   (input valid, input status, input found_age,
                    input entry_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/skt_dpath.sv =====
`default_nettype none

module skt_dpath #(
    parameter int unsigned CAPACITY = 64
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [skt_pkg::CMD_W-1:0]   i_command,
    input  wire logic [skt_pkg::KEY_W-1:0]   i_key,
    input  wire logic [skt_pkg::KEY_W-1:0]   i_new_key,
    input  wire logic [skt_pkg::AGE_W-1:0]   i_age,
    input  wire logic                        i_out_ready,
    output logic                             o_out_valid,
    output logic [skt_pkg::ST_W-1:0]         o_status,
    output logic [skt_pkg::AGE_W-1:0]        o_found_age,
    output logic [skt_pkg::CNT_W-1:0]        o_entry_count,
    input  wire skt_pkg::t_ctl_cmd           i_cmd,
    output skt_pkg::t_ctl_sts                o_sts
);

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned DW = skt_pkg::KEY_W + skt_pkg::AGE_W;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    // Each entry holds the key in the upper half and the age in the lower half.
    logic [DW-1:0] mem [CAPACITY];

    logic [skt_pkg::CMD_W-1:0] r_op;
    logic [skt_pkg::KEY_W-1:0] r_key;
    logic [skt_pkg::KEY_W-1:0] r_nkey;
    logic [skt_pkg::AGE_W-1:0] r_age;
    logic [skt_pkg::AGE_W-1:0] r_hage;
    logic [skt_pkg::ST_W-1:0]  r_code;
    logic [CW-1:0]             r_count;
    logic [CW-1:0]             r_ptr;
    logic [CW-1:0]             r_pos;
    logic [CW-1:0]             r_hidx;
    logic [CW-1:0]             r_raddr;
    logic                      r_hit;
    logic                      r_nhit;
    logic [DW-1:0]             r_rdata;
    logic                      r_rvld;
    logic                      r_ovld;
    logic [skt_pkg::ST_W-1:0]  r_ostatus;
    logic [skt_pkg::AGE_W-1:0] r_oage;
    logic [skt_pkg::CNT_W-1:0] r_ocnt;

    logic [CW-1:0]                n_ptr;
    logic [CW-1:0]                rd_addr;
    logic [skt_pkg::KEY_W-1:0]    e_key;
    logic [skt_pkg::AGE_W-1:0]    e_age;
    logic [skt_pkg::KEY_W-1:0]    target;
    logic                         is_upd;
    logic                         wr_en;
    logic [CW-1:0]                wr_addr;
    logic [DW-1:0]                wr_data;
    logic [CW+skt_pkg::CNT_W-1:0] cnt_ext;

    assign rd_addr = i_cmd.rd_dn ? (r_ptr - ONE_C) : r_ptr;
    assign e_key   = r_rdata[DW-1:skt_pkg::AGE_W];
    assign e_age   = r_rdata[skt_pkg::AGE_W-1:0];
    assign is_upd  = (r_op == skt_pkg::OP_UPDATE);
    assign target  = is_upd ? r_nkey : r_key;
    assign cnt_ext = {{skt_pkg::CNT_W{1'b0}}, r_count};

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_pos;
        wr_data = r_rdata;
        if (i_cmd.put) begin
            wr_en   = 1'b1;
            wr_data = {target, r_age};
        end else if (i_cmd.wr_dn && r_rvld) begin
            wr_en   = 1'b1;
            wr_addr = r_raddr - ONE_C;
        end else if (i_cmd.wr_up && r_rvld) begin
            wr_en   = 1'b1;
            wr_addr = r_raddr + ONE_C;
        end
    end

    always_comb begin
        n_ptr = r_ptr;
        if (i_cmd.load) begin
            n_ptr = '0;
        end else if (i_cmd.del_init) begin
            n_ptr = r_hidx + ONE_C;
        end else if (i_cmd.ins_init) begin
            n_ptr = r_count;
        end else if (i_cmd.rd) begin
            n_ptr = i_cmd.rd_dn ? (r_ptr - ONE_C) : (r_ptr + ONE_C);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr[AW-1:0]] <= wr_data;
        end
        if (i_cmd.rd) begin
            r_rdata <= mem[rd_addr[AW-1:0]];
            r_raddr <= rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        if (i_cmd.load) begin
            r_op   <= i_command;
            r_key  <= i_key;
            r_nkey <= i_new_key;
            r_age  <= i_age;
            r_hit  <= 1'b0;
            r_nhit <= 1'b0;
            r_pos  <= '0;
        end else if (i_cmd.scan && r_rvld) begin
            if (e_key == r_key) begin
                r_hit  <= 1'b1;
                r_hidx <= r_raddr;
                r_hage <= e_age;
            end
            if (e_key == r_nkey) begin
                r_nhit <= 1'b1;
            end
            // The record being re-keyed does not count toward the new place.
            if ((e_key < target) && !(is_upd && (e_key == r_key))) begin
                r_pos <= r_pos + ONE_C;
            end
        end
        if (i_cmd.set_code) begin
            r_code <= i_cmd.code;
        end
        if (i_cmd.finish) begin
            r_ostatus <= r_code;
            r_oage    <= ((r_op == skt_pkg::OP_SEARCH) && (r_code == skt_pkg::ST_OK))
                         ? r_hage : '0;
            r_ocnt    <= cnt_ext[skt_pkg::CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_rvld  <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            r_rvld <= i_cmd.rd;
            if (i_cmd.put) begin
                r_count <= r_count + ONE_C;
            end else if (i_cmd.dec_cnt) begin
                r_count <= r_count - ONE_C;
            end
            if (i_cmd.finish) begin
                r_ovld <= 1'b1;
            end else if (i_out_ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    assign o_sts.op       = r_op;
    assign o_sts.hit      = r_hit;
    assign o_sts.nhit     = r_nhit;
    assign o_sts.full     = (r_count == CAP_C);
    assign o_sts.ptr_end  = (r_ptr == r_count);
    assign o_sts.ins_end  = (r_ptr == r_pos);
    assign o_sts.rvld     = r_rvld;
    assign o_sts.out_free = !r_ovld || i_out_ready;

    assign o_out_valid   = r_ovld;
    assign o_status      = r_ostatus;
    assign o_found_age   = r_oage;
    assign o_entry_count = r_ocnt;

endmodule

`default_nettype wire

// ===== rtl/core/skt_ctrl.sv =====
`default_nettype none

module skt_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire skt_pkg::t_ctl_sts  i_sts,
    output skt_pkg::t_ctl_cmd       o_cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SCAN     = 3'd1;
    localparam logic [2:0] S_DECIDE   = 3'd2;
    localparam logic [2:0] S_DEL      = 3'd3;
    localparam logic [2:0] S_INS_INIT = 3'd4;
    localparam logic [2:0] S_INS      = 3'd5;
    localparam logic [2:0] S_PUT      = 3'd6;
    localparam logic [2:0] S_FINISH   = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                o_cmd.rd   = !i_sts.ptr_end;
                if (i_sts.ptr_end && !i_sts.rvld) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd.set_code = 1'b1;
                o_cmd.code     = skt_pkg::ST_OK;
                n_state        = S_FINISH;
                case (i_sts.op)
                    skt_pkg::OP_INSERT: begin
                        if (i_sts.hit) begin
                            o_cmd.code = skt_pkg::ST_PRESENT;
                        end else if (i_sts.full) begin
                            o_cmd.code = skt_pkg::ST_FULL;
                        end else begin
                            n_state = S_INS_INIT;
                        end
                    end
                    skt_pkg::OP_SEARCH: begin
                        if (!i_sts.hit) begin
                            o_cmd.code = skt_pkg::ST_NOT_FOUND;
                        end
                    end
                    skt_pkg::OP_UPDATE: begin
                        if (!i_sts.hit) begin
                            o_cmd.code = skt_pkg::ST_NOT_FOUND;
                        end else if (i_sts.nhit) begin
                            o_cmd.code = skt_pkg::ST_PRESENT;
                        end else begin
                            o_cmd.del_init = 1'b1;
                            n_state        = S_DEL;
                        end
                    end
                    skt_pkg::OP_DELETE: begin
                        if (!i_sts.hit) begin
                            o_cmd.code = skt_pkg::ST_NOT_FOUND;
                        end else begin
                            o_cmd.del_init = 1'b1;
                            n_state        = S_DEL;
                        end
                    end
                    default: begin
                        n_state = S_FINISH;
                    end
                endcase
            end
            S_DEL: begin
                o_cmd.wr_dn = 1'b1;
                o_cmd.rd    = !i_sts.ptr_end;
                if (i_sts.ptr_end && !i_sts.rvld) begin
                    o_cmd.dec_cnt = 1'b1;
                    n_state = (i_sts.op == skt_pkg::OP_UPDATE) ? S_INS_INIT : S_FINISH;
                end
            end
            S_INS_INIT: begin
                o_cmd.ins_init = 1'b1;
                n_state        = S_INS;
            end
            S_INS: begin
                o_cmd.wr_up = 1'b1;
                o_cmd.rd    = !i_sts.ins_end;
                o_cmd.rd_dn = !i_sts.ins_end;
                if (i_sts.ins_end && !i_sts.rvld) begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                o_cmd.put = 1'b1;
                n_state   = S_FINISH;
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // No command is taken while reset is held.
    assign o_in_ready = (r_state == S_IDLE) && i_rst_n;

endmodule

`default_nettype wire

// ===== rtl/core/sorted_key_table.sv =====
// A search or a failed command makes one scan over the held records; a
// successful update also shifts records down and then up. The scans and shifts
// of the record memory, through its one read port, go one entry per cycle.
// Throughput: one command at a time; the next is taken once the response is loaded.
// Reset: the state machine, record count and valid flags clear; memory is not cleared.
`default_nettype none

module sorted_key_table #(
    parameter int unsigned CAPACITY = 64
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    skt_in_if.sink     i_in,
    skt_out_if.source  o_out
);

    // The table keeps up to CAPACITY records of a unique key and an age in
    // ascending key order, in one memory with a registered read port.
    //
    // Every command begins with a scan over the held records. The scan finds
    // the record whose key matches, notes whether the replacement key is
    // already present, and counts the keys that sort below the key to be
    // placed. For an update, the record being re-keyed is left out of that
    // count, so the count is the place of the new record after the old one
    // has been taken out.
    //
    // A delete, or the first half of an update, closes the gap by moving every
    // record after the hit one place down. An insert, or the second half of an
    // update, opens a gap by moving the records from the top down to the
    // insertion place one place up, and then writes the new record into it.
    // Both moves read one entry per cycle and write it back in the cycle after,
    // so the read and the write never meet at the same address.
    //
    // The response goes into an output register, and the controller returns
    // to idle as soon as it is loaded, so a new command transfer can be taken
    // while the previous response still waits to be taken.

    skt_pkg::t_ctl_cmd ctl_cmd;
    skt_pkg::t_ctl_sts ctl_sts;
    logic              in_ready;

    skt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (ctl_sts),
        .o_cmd      (ctl_cmd)
    );

    skt_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_command     (i_in.command),
        .i_key         (i_in.key),
        .i_new_key     (i_in.new_key),
        .i_age         (i_in.age),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_status      (o_out.status),
        .o_found_age   (o_out.found_age),
        .o_entry_count (o_out.entry_count),
        .i_cmd         (ctl_cmd),
        .o_sts         (ctl_sts)
    );

    // A command transfer completes only while the controller is idle.
    assign i_in.ready = in_ready;

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    // Size of the record store in the block under test.
    localparam int unsigned CAPACITY  = 64;
    // Longest pause that either side of a channel takes before a transfer.
    localparam int unsigned STALL_MAX = 19;
    // The slowest command is an update that shifts the whole store. The limit
    // adds both stalls on top of it and allows many times that.
    localparam int unsigned QUIET_MAX = 2000;
    // Quiet cycles at the end, so that any stray response still shows up.
    localparam int unsigned SETTLE    = 2 * CAPACITY + 20;

    localparam logic [skt_pkg::KEY_W-1:0] KEY_TOP = '1;
    localparam logic [skt_pkg::AGE_W-1:0] AGE_TOP = '1;

    // One response as the block returns it.
    typedef struct packed {
        logic [skt_pkg::ST_W-1:0]  status;
        logic [skt_pkg::AGE_W-1:0] found_age;
        logic [skt_pkg::CNT_W-1:0] entry_count;
    } t_reply;

    // One command. Where known is set, want is the response read straight off
    // the rules; otherwise the record-store model works the response out.
    typedef struct packed {
        logic [skt_pkg::CMD_W-1:0] op;
        logic [skt_pkg::KEY_W-1:0] key;
        logic [skt_pkg::KEY_W-1:0] new_key;
        logic [skt_pkg::AGE_W-1:0] age;
        logic                      known;
        t_reply                    want;
    } t_step;

    // Mixes of commands for the random part: grow the store until it is full,
    // work on a well-populated store, and empty it again.
    typedef enum int {FILLING, MIXING, DRAINING} t_load_mode;

    logic i_clk;
    logic i_rst_n;

    skt_in_if  cmd_if ();
    skt_out_if rsp_if ();

    sorted_key_table #(
        .CAPACITY(CAPACITY)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (cmd_if),
        .o_out  (rsp_if)
    );

    // Directed opening: the empty store, extreme keys and ages, a duplicate
    // insert, updating the head record, updating a record to its own key or to
    // another present key, and moving the tail record to the head.
    t_step opening_steps [24] = '{
        '{skt_pkg::OP_SEARCH, 31'd0, 31'd0, 31'd0, 1'b1,
          '{skt_pkg::ST_NOT_FOUND, 31'd0, 7'd0}},
        '{skt_pkg::OP_DELETE, KEY_TOP, 31'd0, 31'd0, 1'b1,
          '{skt_pkg::ST_NOT_FOUND, 31'd0, 7'd0}},
        '{skt_pkg::OP_UPDATE, 31'd5, 31'd6, 31'd9, 1'b1,
          '{skt_pkg::ST_NOT_FOUND, 31'd0, 7'd0}},
        '{skt_pkg::OP_INSERT, 31'd0, KEY_TOP, AGE_TOP, 1'b1,
          '{skt_pkg::ST_OK, 31'd0, 7'd1}},
        '{skt_pkg::OP_INSERT, KEY_TOP, 31'd0, 31'd0, 1'b1,
          '{skt_pkg::ST_OK, 31'd0, 7'd2}},
        '{skt_pkg::OP_INSERT, 31'd0, 31'd0, 31'd5, 1'b1,
          '{skt_pkg::ST_PRESENT, 31'd0, 7'd2}},
        '{skt_pkg::OP_SEARCH, 31'd0, KEY_TOP, AGE_TOP, 1'b1,
          '{skt_pkg::ST_OK, AGE_TOP, 7'd2}},
        '{skt_pkg::OP_SEARCH, KEY_TOP, 31'd0, 31'd0, 1'b1,
          '{skt_pkg::ST_OK, 31'd0, 7'd2}},
        '{skt_pkg::OP_INSERT, 31'd1000, 31'd0, 31'd55, 1'b1,
          '{skt_pkg::ST_OK, 31'd0, 7'd3}},
        '{skt_pkg::OP_UPDATE, 31'd0, 31'd2000, 31'd1, 1'b1,
          '{skt_pkg::ST_OK, 31'd0, 7'd3}},
        '{skt_pkg::OP_SEARCH, 31'd2000, 31'd0, 31'd0, 1'b1,
          '{skt_pkg::ST_OK, 31'd1, 7'd3}},
        '{skt_pkg::OP_UPDATE, 31'd2000, 31'd2000, 31'd7, 1'b1,
          '{skt_pkg::ST_PRESENT, 31'd0, 7'd3}},
        '{skt_pkg::OP_UPDATE, 31'd2000, 31'd1000, 31'd7, 1'b1,
          '{skt_pkg::ST_PRESENT, 31'd0, 7'd3}},
        '{skt_pkg::OP_SEARCH, 31'd0, 31'd0, 31'd0, 1'b1,
          '{skt_pkg::ST_NOT_FOUND, 31'd0, 7'd3}},
        '{skt_pkg::OP_DELETE, 31'd1000, 31'd0, 31'd0, 1'b1,
          '{skt_pkg::ST_OK, 31'd0, 7'd2}},
        '{skt_pkg::OP_DELETE, 31'd1000, 31'd0, 31'd0, 1'b1,
          '{skt_pkg::ST_NOT_FOUND, 31'd0, 7'd2}},
        '{skt_pkg::OP_UPDATE, KEY_TOP, 31'd0, AGE_TOP, 1'b1,
          '{skt_pkg::ST_OK, 31'd0, 7'd2}},
        '{skt_pkg::OP_SEARCH, 31'd0, 31'd0, 31'd0, 1'b1,
          '{skt_pkg::ST_OK, AGE_TOP, 7'd2}},
        '{skt_pkg::OP_INSERT, 31'h2AAA_AAAA, 31'd0, 31'h5555_5555, 1'b0, '0},
        '{skt_pkg::OP_INSERT, 31'h5555_5555, 31'd0, 31'h2AAA_AAAA, 1'b0, '0},
        '{skt_pkg::OP_SEARCH, 31'h2AAA_AAAA, 31'd0, 31'd0, 1'b0, '0},
        '{skt_pkg::OP_SEARCH, 31'h5555_5555, 31'd0, 31'd0, 1'b0, '0},
        '{skt_pkg::OP_DELETE, 31'd0, 31'd0, 31'd0, 1'b1,
          '{skt_pkg::ST_OK, 31'd0, 7'd3}},
        '{skt_pkg::OP_DELETE, 31'h5555_5555, 31'd0, 31'd0, 1'b0, '0}
    };

    // Model of the record store: keys in ascending order, ages alongside.
    logic [skt_pkg::KEY_W-1:0] held_keys [$];
    logic [skt_pkg::AGE_W-1:0] held_ages [$];

    // Responses still owed by the block, oldest first.
    t_reply awaited [$];

    int unsigned errors    = 0;
    int unsigned n_checked = 0;
    int unsigned peak_held = 0;
    int unsigned op_seen [4] = '{0, 0, 0, 0};
    int unsigned st_seen [4] = '{0, 0, 0, 0};

    // While set, neither side inserts pauses, so commands follow back to back.
    bit no_idle = 1'b0;

    // Position of a key in the model, or -1 when it is not held.
    function automatic int slot_of(logic [skt_pkg::KEY_W-1:0] k);
        foreach (held_keys[i]) begin
            if (held_keys[i] == k) return i;
        end
        return -1;
    endfunction

    // Put a record at its place in key order.
    function automatic void place_sorted(logic [skt_pkg::KEY_W-1:0] k,
                                         logic [skt_pkg::AGE_W-1:0] a);
        int pos;
        pos = 0;
        while (pos < held_keys.size() && held_keys[pos] < k) pos++;
        held_keys.insert(pos, k);
        held_ages.insert(pos, a);
    endfunction

    // Carry out one command on the model and return the response it owes.
    // A present key is reported before a full store, and an update may not
    // keep the key that the record already has.
    function automatic t_reply run_command(logic [skt_pkg::CMD_W-1:0] op,
                                           logic [skt_pkg::KEY_W-1:0] k,
                                           logic [skt_pkg::KEY_W-1:0] nk,
                                           logic [skt_pkg::AGE_W-1:0] a);
        t_reply r;
        int     at;
        r        = '0;
        r.status = skt_pkg::ST_OK;
        at       = slot_of(k);
        case (op)
            skt_pkg::OP_INSERT: begin
                if (at >= 0) r.status = skt_pkg::ST_PRESENT;
                else if (held_keys.size() >= CAPACITY) r.status = skt_pkg::ST_FULL;
                else place_sorted(k, a);
            end
            skt_pkg::OP_SEARCH: begin
                if (at < 0) r.status = skt_pkg::ST_NOT_FOUND;
                else r.found_age = held_ages[at];
            end
            skt_pkg::OP_UPDATE: begin
                if (at < 0) begin
                    r.status = skt_pkg::ST_NOT_FOUND;
                end else if (slot_of(nk) >= 0) begin
                    r.status = skt_pkg::ST_PRESENT;
                end else begin
                    held_keys.delete(at);
                    held_ages.delete(at);
                    place_sorted(nk, a);
                end
            end
            default: begin
                if (at < 0) begin
                    r.status = skt_pkg::ST_NOT_FOUND;
                end else begin
                    held_keys.delete(at);
                    held_ages.delete(at);
                end
            end
        endcase
        r.entry_count = skt_pkg::CNT_W'(held_keys.size());
        if (held_keys.size() > peak_held) peak_held = held_keys.size();
        return r;
    endfunction

    // A key that is held with the given likelihood in percent; otherwise a
    // full-range key, one from a crowded low range, or one near either end.
    function automatic logic [skt_pkg::KEY_W-1:0] pick_key(int unsigned held_pct);
        logic [31:0] raw;
        int unsigned roll;
        raw  = $urandom;
        roll = $urandom_range(0, 99);
        if (held_keys.size() != 0 && roll < held_pct)
            return held_keys[$urandom_range(0, held_keys.size() - 1)];
        roll = $urandom_range(0, 9);
        if (roll < 5) return raw[skt_pkg::KEY_W-1:0];
        if (roll < 8) return skt_pkg::KEY_W'(raw[7:0]);
        if (roll == 8) return KEY_TOP - skt_pkg::KEY_W'(raw[1:0]);
        return skt_pkg::KEY_W'(raw[1:0]);
    endfunction

    function automatic logic [skt_pkg::AGE_W-1:0] pick_age();
        logic [31:0] raw;
        int unsigned roll;
        raw  = $urandom;
        roll = $urandom_range(0, 9);
        if (roll == 0) return '0;
        if (roll == 1) return AGE_TOP;
        return raw[skt_pkg::AGE_W-1:0];
    endfunction

    // Offer one command and hold it until the block takes it. The model is
    // advanced at the edge of the transfer, so the next random command is
    // drawn against the store as the block will see it.
    task automatic send_command(t_step s);
        int unsigned pause;
        t_reply      r;
        pause = no_idle ? 0 : $urandom_range(0, STALL_MAX);
        if (pause != 0) begin
            cmd_if.valid <= 1'b0;
            repeat (pause) @(posedge i_clk);
        end
        cmd_if.valid   <= 1'b1;
        cmd_if.command <= s.op;
        cmd_if.key     <= s.key;
        cmd_if.new_key <= s.new_key;
        cmd_if.age     <= s.age;
        @(posedge i_clk);
        while (cmd_if.ready !== 1'b1) @(posedge i_clk);
        r = run_command(s.op, s.key, s.new_key, s.age);
        awaited.push_back(s.known ? s.want : r);
        op_seen[s.op]++;
    endtask

    // Draw one command in the given mix and send it. Keys are mostly taken
    // from the store while mixing or draining, so that searches, updates and
    // deletes find their record most of the time; the rest miss on purpose.
    task automatic send_random(t_load_mode mode);
        t_step       s;
        int unsigned roll;
        int unsigned held_pct;
        s    = '0;
        roll = $urandom_range(0, 99);
        case (mode)
            FILLING: begin
                held_pct = 20;
                s.op = roll < 80 ? skt_pkg::OP_INSERT : roll < 88 ? skt_pkg::OP_SEARCH :
                       roll < 95 ? skt_pkg::OP_UPDATE : skt_pkg::OP_DELETE;
            end
            DRAINING: begin
                held_pct = 75;
                s.op = roll < 70 ? skt_pkg::OP_DELETE : roll < 80 ? skt_pkg::OP_INSERT :
                       roll < 90 ? skt_pkg::OP_SEARCH : skt_pkg::OP_UPDATE;
            end
            default: begin
                held_pct = 60;
                s.op = roll < 25 ? skt_pkg::OP_INSERT : roll < 50 ? skt_pkg::OP_SEARCH :
                       roll < 75 ? skt_pkg::OP_UPDATE : skt_pkg::OP_DELETE;
            end
        endcase
        s.key = pick_key(held_pct);
        // The replacement key clashes now and then, with another record or
        // with the record's own key.
        roll = $urandom_range(0, 99);
        if (roll < 25) s.new_key = pick_key(100);
        else if (roll < 30) s.new_key = s.key;
        else s.new_key = pick_key(0);
        s.age = pick_age();
        send_command(s);
    endtask

    task automatic wait_for_replies();
        while (awaited.size() != 0) @(posedge i_clk);
    endtask

    function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: response %0d, %s: expected %0d, got %0d",
                     $time, n_checked, what, want, got);
        end
    endfunction

    initial begin : clock_gen
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Stimulus: reset, the directed opening, then three rounds that each fill
    // the store to capacity, keep working on it, and empty it again.
    initial begin : command_side
        i_rst_n        <= 1'b0;
        cmd_if.valid   <= 1'b0;
        cmd_if.command <= skt_pkg::OP_INSERT;
        cmd_if.key     <= '0;
        cmd_if.new_key <= '0;
        cmd_if.age     <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (opening_steps[i]) send_command(opening_steps[i]);

        for (int round = 0; round < 3; round++) begin
            while (held_keys.size() < CAPACITY) send_random(FILLING);
            // The store is full now: new keys are refused, present ones still
            // report as present.
            repeat (12) send_random(FILLING);
            // In the second round the middle stretch runs without any pauses.
            if (round == 1) no_idle = 1'b1;
            repeat (40) send_random(MIXING);
            no_idle = 1'b0;
            while (held_keys.size() != 0) send_random(DRAINING);
            repeat (8) send_random(DRAINING);
            // Hold back until the block has answered everything so far.
            cmd_if.valid <= 1'b0;
            wait_for_replies();
        end

        wait_for_replies();
        repeat (SETTLE) @(posedge i_clk);
        $display("Sent %0d inserts, %0d searches, %0d updates, %0d deletes; %0d responses.",
                 op_seen[skt_pkg::OP_INSERT], op_seen[skt_pkg::OP_SEARCH],
                 op_seen[skt_pkg::OP_UPDATE], op_seen[skt_pkg::OP_DELETE], n_checked);
        $display("Outcomes: %0d ok, %0d not found, %0d present, %0d full; peak %0d of %0d.",
                 st_seen[skt_pkg::ST_OK], st_seen[skt_pkg::ST_NOT_FOUND],
                 st_seen[skt_pkg::ST_PRESENT], st_seen[skt_pkg::ST_FULL],
                 peak_held, CAPACITY);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Response side: stall at random, then take each response and compare it
    // with the oldest one owed.
    initial begin : reply_side
        int unsigned stall;
        t_reply      want;
        rsp_if.ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, STALL_MAX);
            if (stall != 0) begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            @(posedge i_clk);
            while (rsp_if.valid !== 1'b1) @(posedge i_clk);
            n_checked++;
            if (awaited.size() == 0) begin
                errors++;
                $display("%0t: response with no command outstanding: expected none, got %0d %0d %0d",
                         $time, rsp_if.status, rsp_if.found_age, rsp_if.entry_count);
            end else begin
                want = awaited.pop_front();
                st_seen[want.status]++;
                check_field("status", 32'(want.status), 32'(rsp_if.status));
                check_field("found_age", 32'(want.found_age), 32'(rsp_if.found_age));
                check_field("entry_count", 32'(want.entry_count), 32'(rsp_if.entry_count));
            end
        end
    end

    // Ends the run if no transfer happens on either channel for too long.
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_MAX) begin
            @(posedge i_clk);
            if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet = 0;
            else quiet++;
        end
        $display("%0t: no transfer for %0d cycles, %0d responses still owed",
                 $time, QUIET_MAX, awaited.size());
        $display("TB_ERROR");
        $finish;
    end

endmodule
